### hw/rtl/pnz_pkg.sv
// pnz_pkg: shared constants and types for the 2-d gradient noise block
// no dependencies

package pnz_pkg;

    localparam int TABLE_SIZE_DEF = 256;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int OUT_W          = 19;
    localparam int POS_W          = 32;
    localparam int BYTE_W         = 8;
    localparam int QUEUE_DEPTH    = 4;

    typedef enum logic [0:0] {
        KIND_EVAL  = 1'b0,
        KIND_WRITE = 1'b1
    } kind_t;

endpackage

### hw/rtl/pnz_ram.sv
// pnz_ram: generic single write, single read ram with registered read
// no dependencies

module pnz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

### hw/rtl/pnz_front.sv
// pnz_front: accepts words, writes table bytes and hashes the four cell corners
// depends on pnz_pkg and pnz_ram

module pnz_front #(
    parameter int TABLE_SIZE = pnz_pkg::TABLE_SIZE_DEF,
    parameter int FRAC_BITS  = pnz_pkg::FRAC_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   in_kind,
    input  logic [7:0]             in_index,
    input  logic [7:0]             in_value,
    input  logic [31:0]            in_x,
    input  logic [31:0]            in_y,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [4*3-1:0]         out_grad,
    output logic [FRAC_BITS-1:0]   out_xf,
    output logic [FRAC_BITS-1:0]   out_yf
);

    localparam int AW = $clog2(TABLE_SIZE);

    // stage 1 and stage 2 control and payload
    logic                 v1_reg, v2_reg;
    logic                 en;
    logic [AW-1:0]        yi1_reg, yj1_reg;
    logic [FRAC_BITS-1:0] xf1_reg, yf1_reg, xf2_reg, yf2_reg;
    logic [AW-1:0]        xi, xj;
    logic [pnz_pkg::BYTE_W-1:0] pa, pb, ha0, ha1, hb0, hb1;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;

    // pipe advances when the last stage is empty or drained
    assign en        = !v2_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = v2_reg;

    assign xi      = in_x[FRAC_BITS +: AW];
    assign xj      = xi + AW'(1);
    assign wr_en   = in_valid && en && (in_kind == pnz_pkg::KIND_WRITE);
    assign wr_addr = AW'(in_index);

    // first hash level: perm[x] and perm[x+1]
    pnz_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram_a (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(in_value),
        .rd_en(en), .rd_addr(xi), .rd_data(pa));
    pnz_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram_b (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(in_value),
        .rd_en(en), .rd_addr(xj), .rd_data(pb));

    // second hash level, one copy per corner
    logic [AW-1:0] a0, a1, b0, b1;
    assign a0 = AW'(pa) + yi1_reg;
    assign a1 = AW'(pa) + yj1_reg;
    assign b0 = AW'(pb) + yi1_reg;
    assign b1 = AW'(pb) + yj1_reg;

    pnz_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram_aa (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(in_value),
        .rd_en(en), .rd_addr(a0), .rd_data(ha0));
    pnz_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram_ab (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(in_value),
        .rd_en(en), .rd_addr(a1), .rd_data(ha1));
    pnz_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram_ba (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(in_value),
        .rd_en(en), .rd_addr(b0), .rd_data(hb0));
    pnz_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram_bb (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(in_value),
        .rd_en(en), .rd_addr(b1), .rd_data(hb1));

    // valid tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid && (in_kind == pnz_pkg::KIND_EVAL);
            v2_reg <= v1_reg;
        end
    end

    // payload alongside the table reads
    always_ff @(posedge aclk) begin
        if (en) begin
            yi1_reg <= in_y[FRAC_BITS +: AW];
            yj1_reg <= in_y[FRAC_BITS +: AW] + AW'(1);
            xf1_reg <= in_x[FRAC_BITS-1:0];
            yf1_reg <= in_y[FRAC_BITS-1:0];
            xf2_reg <= xf1_reg;
            yf2_reg <= yf1_reg;
        end
    end

    assign out_grad = {hb1[2:0], hb0[2:0], ha1[2:0], ha0[2:0]};
    assign out_xf   = xf2_reg;
    assign out_yf   = yf2_reg;

endmodule

### hw/rtl/pnz_queue.sv
// pnz_queue: small fifo between hashing front and blending back
// depends on pnz_pkg

module pnz_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int D  = pnz_pkg::QUEUE_DEPTH;
    localparam int AW = $clog2(D);

    logic [WIDTH-1:0] slot_reg [D];
    logic [AW-1:0]    wp_reg, rp_reg;
    logic [AW:0]      cnt_reg;
    logic             push, pop;

    assign in_ready  = cnt_reg != (AW+1)'(D);
    assign out_valid = cnt_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = slot_reg[rp_reg];

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + AW'(1);
            if (pop)  rp_reg <= rp_reg + AW'(1);
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wp_reg] <= in_data;
        end
    end

endmodule

### hw/rtl/pnz_back.sv
// pnz_back: fade curves, gradient dot products and lerps, fully pipelined
// depends on pnz_pkg

module pnz_back #(
    parameter int FRAC_BITS = pnz_pkg::FRAC_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [11:0]               in_grad,
    input  logic [FRAC_BITS-1:0]      in_xf,
    input  logic [FRAC_BITS-1:0]      in_yf,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [pnz_pkg::OUT_W-1:0] out_noise
);

    localparam int F  = FRAC_BITS;
    localparam int W  = F + 6;      // signed working width for blend values
    localparam int PW = 2 * W + 8;  // product width
    localparam int NS = 7;

    // truncating fixed-point product toward zero
    function automatic logic signed [PW-1:0] fxm(input logic signed [W+2:0] a,
                                                 input logic signed [W+2:0] b);
        logic signed [PW-1:0] p;
        logic signed [PW-1:0] q;
        p = PW'(a) * PW'(b);
        q = p < 0 ? -((-p) >>> F) : (p >>> F);
        return q;
    endfunction

    // gradient selection
    function automatic logic signed [W-1:0] grad(input logic [2:0] h,
                                                 input logic signed [W-1:0] x,
                                                 input logic signed [W-1:0] y);
        logic signed [W-1:0] r;
        case (h)
            3'd0:    r = x + y;
            3'd1:    r = y - x;
            3'd2:    r = x - y;
            3'd3:    r = -x - y;
            3'd4:    r = x;
            3'd5:    r = -x;
            3'd6:    r = y;
            default: r = -y;
        endcase
        return r;
    endfunction

    typedef logic signed [W+2:0] val_t;

    logic            en;
    logic [NS-1:0]   v_reg;
    logic            ob_v_reg;
    logic [pnz_pkg::OUT_W-1:0] ob_reg;

    // pipeline advances unless the output register is held
    assign en        = !ob_v_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = ob_v_reg;
    assign out_noise = ob_reg;

    val_t one_c;
    assign one_c = val_t'(1) <<< F;

    // stage 1: gradients, t*t, t*(6t-15)
    val_t s1_u_tt, s1_v_tt, s1_u_t, s1_v_t, s1_u_i, s1_v_i;
    val_t s1_g0, s1_g1, s1_g2, s1_g3;
    // stage 2: cube partial, inner partial
    val_t s2_u_t, s2_v_t, s2_u_tt, s2_v_tt, s2_u_in, s2_v_in;
    val_t s2_g0, s2_g1, s2_g2, s2_g3;
    // stage 3: cube, inner+10
    val_t s3_u_c, s3_v_c, s3_u_in, s3_v_in, s3_g0, s3_g1, s3_g2, s3_g3;
    // stage 4: fade values
    val_t s4_u, s4_v, s4_g0, s4_g1, s4_g2, s4_g3;
    // stage 5: v lerp products
    val_t s5_u, s5_p0, s5_p1, s5_g0, s5_g2;
    // stage 6: x1, x2-x1
    val_t s6_u, s6_x1, s6_d;
    // stage 7: final product
    val_t s7_x1, s7_p;

    logic signed [W-1:0] xf_s, yf_s, xm_s, ym_s;
    assign xf_s = W'({1'b0, in_xf});
    assign yf_s = W'({1'b0, in_yf});
    assign xm_s = xf_s - (W'(1) <<< F);
    assign ym_s = yf_s - (W'(1) <<< F);

    // valid shift line
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg    <= '0;
            ob_v_reg <= 1'b0;
        end else if (en) begin
            v_reg    <= {v_reg[NS-2:0], in_valid};
            ob_v_reg <= v_reg[NS-1];
        end
    end

    // arithmetic stages, at most one multiplier level each
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_u_t  <= val_t'(xf_s);
            s1_v_t  <= val_t'(yf_s);
            s1_u_tt <= val_t'(fxm(val_t'(xf_s), val_t'(xf_s)));
            s1_v_tt <= val_t'(fxm(val_t'(yf_s), val_t'(yf_s)));
            s1_u_i  <= val_t'(fxm(val_t'(xf_s), val_t'(6 * val_t'(xf_s) - 15 * one_c)));
            s1_v_i  <= val_t'(fxm(val_t'(yf_s), val_t'(6 * val_t'(yf_s) - 15 * one_c)));
            s1_g0   <= val_t'(grad(in_grad[2:0],  xf_s, yf_s));
            s1_g1   <= val_t'(grad(in_grad[5:3],  xf_s, ym_s));
            s1_g2   <= val_t'(grad(in_grad[8:6],  xm_s, yf_s));
            s1_g3   <= val_t'(grad(in_grad[11:9], xm_s, ym_s));

            s2_u_t  <= s1_u_t;  s2_v_t  <= s1_v_t;
            s2_u_tt <= s1_u_tt; s2_v_tt <= s1_v_tt;
            s2_u_in <= val_t'(s1_u_i + 10 * one_c);
            s2_v_in <= val_t'(s1_v_i + 10 * one_c);
            s2_g0 <= s1_g0; s2_g1 <= s1_g1; s2_g2 <= s1_g2; s2_g3 <= s1_g3;

            s3_u_c  <= val_t'(fxm(s2_u_tt, s2_u_t));
            s3_v_c  <= val_t'(fxm(s2_v_tt, s2_v_t));
            s3_u_in <= s2_u_in; s3_v_in <= s2_v_in;
            s3_g0 <= s2_g0; s3_g1 <= s2_g1; s3_g2 <= s2_g2; s3_g3 <= s2_g3;

            s4_u <= val_t'(fxm(s3_u_c, s3_u_in));
            s4_v <= val_t'(fxm(s3_v_c, s3_v_in));
            s4_g0 <= s3_g0; s4_g1 <= s3_g1; s4_g2 <= s3_g2; s4_g3 <= s3_g3;

            s5_u  <= s4_u;
            s5_p0 <= val_t'(fxm(s4_v, s4_g1 - s4_g0));
            s5_p1 <= val_t'(fxm(s4_v, s4_g3 - s4_g2));
            s5_g0 <= s4_g0; s5_g2 <= s4_g2;

            s6_u  <= s5_u;
            s6_x1 <= s5_g0 + s5_p0;
            s6_d  <= (s5_g2 + s5_p1) - (s5_g0 + s5_p0);

            s7_x1 <= s6_x1;
            s7_p  <= val_t'(fxm(s6_u, s6_d));

            ob_reg <= pnz_pkg::OUT_W'(s7_x1 + s7_p);
        end
    end

endmodule

### hw/rtl/perlin_noise_2d_eval_top.sv
// throughput: one word per cycle while the output is not stalled, table writes and evaluations interleaved freely
// the permutation table lives in six ram copies, one write port each, so every
// corner hash is read in the same cycle
// reset: aresetn, synchronous, active low; clears valid and queue state only
// top level of the 2-d noise block; depends on pnz_pkg, pnz_front, pnz_queue, pnz_back

module perlin_noise_2d_eval_top #(
    parameter int TABLE_SIZE = pnz_pkg::TABLE_SIZE_DEF,
    parameter int FRAC_BITS  = pnz_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // table_index[7:0], table_value[15:8], pos_x[47:16], pos_y[79:48]
    input  logic        s_tuser,  // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // noise_value[18:0], zero fill above
);

    localparam int QW = 12 + 2 * FRAC_BITS;

    logic                 f_valid, f_ready, q_valid, q_ready;
    logic [11:0]          f_grad;
    logic [FRAC_BITS-1:0] f_xf, f_yf;
    logic [QW-1:0]        q_data;
    logic [pnz_pkg::OUT_W-1:0] noise;

    // front: table writes and corner hashing
    pnz_front #(.TABLE_SIZE(TABLE_SIZE), .FRAC_BITS(FRAC_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_kind(s_tuser),
        .in_index(s_tdata[7:0]), .in_value(s_tdata[15:8]),
        .in_x(s_tdata[47:16]), .in_y(s_tdata[79:48]),
        .out_valid(f_valid), .out_ready(f_ready),
        .out_grad(f_grad), .out_xf(f_xf), .out_yf(f_yf));

    // queue between the halves
    pnz_queue #(.WIDTH(QW)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(f_valid), .in_ready(f_ready), .in_data({f_yf, f_xf, f_grad}),
        .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data));

    // back: fade and blend
    pnz_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(q_valid), .in_ready(q_ready),
        .in_grad(q_data[11:0]), .in_xf(q_data[12 +: FRAC_BITS]),
        .in_yf(q_data[12 + FRAC_BITS +: FRAC_BITS]),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_noise(noise));

    assign m_tdata = {5'b0, noise};

endmodule

### hw/rtl/pnz_checker.sv
// pnz_checker: port-level checks on the noise block
// depends on perlin_noise_2d_eval_top ports only

module pnz_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // result word holds while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // zero fill above the noise field
    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:19] == 5'b0)
        else $error("fill bits set");

    // no result right after reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result after reset");

    // a free output never blocks the input side
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind perlin_noise_2d_eval_top pnz_checker u_pnz_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata));
